FILE: hw/rtl/rmv_pkg.sv
// Shared constants and controller/datapath interface types for the running mean/variance block.
`timescale 1ns / 1ps

package rmv_pkg;

    // Default geometry
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COUNT_BITS_DEF     = 20;
    localparam int MEAN_FRAC_BITS_DEF = 16;

    // Fixed result formats
    localparam int MEAN_W       = 32;
    localparam int SUMSQ_W      = 63;
    localparam int SQ_FRAC_BITS = 8;

    // Width of the multiplier operand slice taken from the residual per cycle
    localparam int MUL_CHUNK_BITS = 17;

    localparam logic [SUMSQ_W-1:0] SUMSQ_MAX = {SUMSQ_W{1'b1}};
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0]  MEAN_MIN  = {1'b1, {(MEAN_W-1){1'b0}}};

    typedef struct packed {
        logic load;      // request accepted: capture sample, clear on start_new
        logic prep;      // form delta, load divider
        logic div_step;  // one restoring divide step
        logic mean;      // new mean from quotient
        logic resid;     // residual, clear product accumulator
        logic mul_step;  // one partial product
        logic term;      // scale and clamp product
        logic finish;    // commit state, load result register
    } rmv_cmd_t;

    typedef struct packed {
        logic full;      // count at maximum, sample to be dropped
        logic div_last;  // current divide step is the last
        logic mul_last;  // current partial product is the last
        logic out_busy;  // result register held by receiver stall
    } rmv_status_t;

endpackage

FILE: hw/rtl/running_mean_variance.sv
// Running mean and variance accumulator, top level.
//
// Request channel: sample and start_new with req_valid/req_stall; a request
// is taken on a clock edge with req_valid high and req_stall low. start_new
// clears count, mean and sum of squares before the sample is folded in.
// Result channel: one result per request on res_valid/res_stall, held stable
// while res_stall is high.
// Sequencing: a request is worked on alone. With W = max(SAMPLE_BITS +
// MEAN_FRAC_BITS, 32) + 1, the radix-2 divider takes W steps and the multiplier
// ceil(W/17) partial products; req_stall drops as res_valid rises, and only then
// is the next request taken. A sample that arrives with a full count skips both
// and is reported as dropped.
// A finished result waits in the output register while the next request runs;
// the block holds a further result until the receiver drops res_stall.
// Reset: asynchronous, active low; clears count, mean, sum and res_valid.
`timescale 1ns / 1ps

module running_mean_variance
#(
    parameter int SAMPLE_BITS    = rmv_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS     = rmv_pkg::COUNT_BITS_DEF,
    parameter int MEAN_FRAC_BITS = rmv_pkg::MEAN_FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  logic                               start_new,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [COUNT_BITS-1:0]              sample_count,
    output logic signed [rmv_pkg::MEAN_W-1:0]  running_mean,
    output logic [rmv_pkg::SUMSQ_W-1:0]        sum_sq_dev,
    output logic                               sample_dropped,
    output logic                               sum_saturated
);

    rmv_pkg::rmv_cmd_t    cmd;
    rmv_pkg::rmv_status_t status;

    rmv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .status    (status)
    );

    rmv_datapath
    #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COUNT_BITS     (COUNT_BITS),
        .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (sample),
        .start_new      (start_new),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .sample_count   (sample_count),
        .running_mean   (running_mean),
        .sum_sq_dev     (sum_sq_dev),
        .sample_dropped (sample_dropped),
        .sum_saturated  (sum_saturated)
    );

endmodule

FILE: hw/rtl/rmv_ctrl.sv
// Sequencer for the running mean/variance block.
`timescale 1ns / 1ps

module rmv_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    output rmv_pkg::rmv_cmd_t    cmd,
    input  rmv_pkg::rmv_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MEAN  = 3'd3;
    localparam logic [2:0] ST_RESID = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_TERM  = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.full ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                cmd.mean   = 1'b1;
                state_next = ST_RESID;
            end
            ST_RESID:
            begin
                cmd.resid  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait for the result register to drain
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/rmv_datapath.sv
// Datapath: Welford state, restoring divider, sliced multiplier and result register.
`timescale 1ns / 1ps

module rmv_datapath
#(
    parameter int SAMPLE_BITS    = rmv_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS     = rmv_pkg::COUNT_BITS_DEF,
    parameter int MEAN_FRAC_BITS = rmv_pkg::MEAN_FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rmv_pkg::rmv_cmd_t                  cmd,
    output rmv_pkg::rmv_status_t               status,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  logic                               start_new,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [COUNT_BITS-1:0]              sample_count,
    output logic signed [rmv_pkg::MEAN_W-1:0]  running_mean,
    output logic [rmv_pkg::SUMSQ_W-1:0]        sum_sq_dev,
    output logic                               sample_dropped,
    output logic                               sum_saturated
);

    localparam int MEAN_W  = rmv_pkg::MEAN_W;
    localparam int SUMSQ_W = rmv_pkg::SUMSQ_W;
    localparam int XS_W    = SAMPLE_BITS + MEAN_FRAC_BITS;
    localparam int D_W     = ((XS_W > MEAN_W) ? XS_W : MEAN_W) + 1;
    localparam int MAG_W   = D_W;
    localparam int Q_W     = D_W + 1;
    localparam int NM_W    = Q_W + 1;
    localparam int CHUNK   = rmv_pkg::MUL_CHUNK_BITS;
    localparam int NCHUNK  = (MAG_W + CHUNK - 1) / CHUNK;
    localparam int R_PAD_W = NCHUNK * CHUNK;
    localparam int PP_W    = MAG_W + CHUNK;
    localparam int ACC_W   = MAG_W + R_PAD_W;
    localparam int STEP_W  = $clog2(MAG_W);
    localparam int SHIFT   = 2 * MEAN_FRAC_BITS - rmv_pkg::SQ_FRAC_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [NM_W-1:0] NM_HI =
        $signed({{(NM_W-MEAN_W+1){1'b0}}, {(MEAN_W-1){1'b1}}});
    localparam logic signed [NM_W-1:0] NM_LO = ~NM_HI;

    // accumulator state
    logic [COUNT_BITS-1:0]      count_reg;
    logic signed [MEAN_W-1:0]   mean_reg;
    logic [SUMSQ_W-1:0]         sumsq_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       res_valid_reg;

    // per-request working registers
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic [COUNT_BITS-1:0]      n_reg;
    logic                       drop_reg;
    logic                       d_neg_reg;
    logic [MAG_W-1:0]           d_mag_reg;
    logic [COUNT_BITS-1:0]      rem_reg;
    logic [MAG_W-1:0]           quo_reg;
    logic signed [MEAN_W-1:0]   nm_reg;
    logic [R_PAD_W-1:0]         r_sh_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [SUMSQ_W-1:0]         term_reg;

    // result register
    logic [COUNT_BITS-1:0]      count_out_reg;
    logic signed [MEAN_W-1:0]   mean_out_reg;
    logic [SUMSQ_W-1:0]         sumsq_out_reg;
    logic                       dropped_out_reg;
    logic                       sat_out_reg;

    logic signed [XS_W-1:0]     xs;
    logic signed [D_W-1:0]      xs_ext;
    logic signed [D_W-1:0]      d;
    logic [MAG_W-1:0]           d_mag;
    logic [COUNT_BITS:0]        rem_shift;
    logic [COUNT_BITS:0]        rem_diff;
    logic                       rem_ge;
    logic signed [Q_W-1:0]      q_pos;
    logic signed [Q_W-1:0]      q;
    logic signed [NM_W-1:0]     nm_wide;
    logic signed [MEAN_W-1:0]   nm_sat;
    logic signed [D_W-1:0]      r;
    logic [MAG_W-1:0]           r_mag;
    logic [PP_W-1:0]            pp;
    logic [ACC_W-1:0]           sh;
    logic [SUMSQ_W:0]           sum_wide;
    logic [SUMSQ_W-1:0]         sumsq_upd;
    logic [COUNT_BITS-1:0]      fin_count;
    logic signed [MEAN_W-1:0]   fin_mean;
    logic [SUMSQ_W-1:0]         fin_sumsq;

    // delta = sample scaled to the mean format minus the current mean
    assign xs     = $signed({sample_reg, {MEAN_FRAC_BITS{1'b0}}});
    assign xs_ext = D_W'(xs);
    assign d      = xs_ext - D_W'(mean_reg);
    assign d_mag  = d[D_W-1] ? MAG_W'(-d) : MAG_W'(d);

    // restoring divide of |delta| by n, one quotient bit per step
    assign rem_shift = {rem_reg, quo_reg[MAG_W-1]};
    assign rem_diff  = rem_shift - {1'b0, n_reg};
    assign rem_ge    = !rem_diff[COUNT_BITS];

    // quotient truncates toward zero, so the sign is applied to the magnitude
    assign q_pos   = $signed(Q_W'(quo_reg));
    assign q       = d_neg_reg ? -q_pos : q_pos;
    assign nm_wide = NM_W'(q) + NM_W'(mean_reg);

    always_comb
    begin
        priority if (nm_wide > NM_HI)
        begin
            nm_sat = $signed(rmv_pkg::MEAN_MAX);
        end
        else if (nm_wide < NM_LO)
        begin
            nm_sat = $signed(rmv_pkg::MEAN_MIN);
        end
        else
        begin
            nm_sat = nm_wide[MEAN_W-1:0];
        end
    end

    assign r     = xs_ext - D_W'(nm_reg);
    assign r_mag = r[D_W-1] ? MAG_W'(-r) : MAG_W'(r);

    // |delta| * |r|, residual consumed from its top slice down
    assign pp = PP_W'(d_mag_reg) * PP_W'(r_sh_reg[R_PAD_W-1 -: CHUNK]);

    assign sh        = acc_reg >> SHIFT;
    assign sum_wide  = {1'b0, sumsq_reg} + {1'b0, term_reg};
    assign sumsq_upd = sum_wide[SUMSQ_W] ? rmv_pkg::SUMSQ_MAX : sum_wide[SUMSQ_W-1:0];

    assign fin_count = drop_reg ? count_reg : n_reg;
    assign fin_mean  = drop_reg ? mean_reg  : nm_reg;
    assign fin_sumsq = drop_reg ? sumsq_reg : sumsq_upd;

    assign status.full     = (count_reg == COUNT_MAX);
    assign status.div_last = (step_reg == STEP_W'(MAG_W - 1));
    assign status.mul_last = (step_reg == STEP_W'(NCHUNK - 1));
    assign status.out_busy = res_valid_reg && res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mean_reg      <= '0;
            sumsq_reg     <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && start_new)
            begin
                count_reg <= '0;
                mean_reg  <= '0;
                sumsq_reg <= '0;
            end
            else if (cmd.finish)
            begin
                count_reg <= fin_count;
                mean_reg  <= fin_mean;
                sumsq_reg <= fin_sumsq;
            end

            if (cmd.prep || cmd.resid)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step || cmd.mul_step)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end

        if (cmd.prep)
        begin
            n_reg     <= count_reg + 1'b1;
            drop_reg  <= status.full;
            d_neg_reg <= d[D_W-1];
            d_mag_reg <= d_mag;
            quo_reg   <= d_mag;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
        end

        if (cmd.mean)
        begin
            nm_reg <= nm_sat;
        end

        if (cmd.resid)
        begin
            r_sh_reg <= R_PAD_W'(r_mag);
            acc_reg  <= '0;
        end
        else if (cmd.mul_step)
        begin
            r_sh_reg <= r_sh_reg << CHUNK;
            acc_reg  <= (acc_reg << CHUNK) + ACC_W'(pp);
        end

        if (cmd.term)
        begin
            term_reg <= (sh > ACC_W'(rmv_pkg::SUMSQ_MAX)) ? rmv_pkg::SUMSQ_MAX
                                                          : sh[SUMSQ_W-1:0];
        end

        if (cmd.finish)
        begin
            count_out_reg   <= fin_count;
            mean_out_reg    <= fin_mean;
            sumsq_out_reg   <= fin_sumsq;
            dropped_out_reg <= drop_reg;
            sat_out_reg     <= (fin_sumsq == rmv_pkg::SUMSQ_MAX);
        end
    end

    assign res_valid      = res_valid_reg;
    assign sample_count   = count_out_reg;
    assign running_mean   = mean_out_reg;
    assign sum_sq_dev     = sumsq_out_reg;
    assign sample_dropped = dropped_out_reg;
    assign sum_saturated  = sat_out_reg;

`ifndef SYNTHESIS
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (sat_out_reg == (sumsq_out_reg == rmv_pkg::SUMSQ_MAX)))
        else $error("saturation flag disagrees with sum");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && dropped_out_reg) |-> (count_out_reg == COUNT_MAX))
        else $error("sample dropped while count not full");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < n_reg))
        else $error("divider remainder not below divisor");

    a_cmd_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.prep, cmd.div_step, cmd.mean,
                  cmd.resid, cmd.mul_step, cmd.term, cmd.finish}))
        else $error("more than one datapath command");
`endif

endmodule
